FILE: sv/hrfu_pkg.sv
// Shared types and constants for the H.264 RTP FU-A packetizer.
// Holds the beat structs, configuration types and the front-to-back command format.
// No dependencies.
package hrfu_pkg;

  localparam int LEN_W = 16;          // NAL length and remaining-byte count width
  localparam int HDR_BYTES = 14;      // 12 RTP header bytes plus FU indicator and FU header
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W = $clog2(Q_DEPTH);
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] RTP_BYTE0 = 8'h80;  // version 2, no padding, extension or CSRC
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] NRI_MASK  = 8'he0;
  localparam logic [7:0] TYPE_MASK = 8'h1f;
  localparam logic [7:0] FU_S_BIT  = 8'h80;
  localparam logic [7:0] FU_E_BIT  = 8'h40;

  typedef logic [3:0] pos_t;
  localparam pos_t POS_HDR_FIRST = 4'd0;
  localparam pos_t POS_HDR_LAST  = 4'd11;
  localparam pos_t POS_FU_IND    = 4'd12;
  localparam pos_t POS_PAYLOAD   = 4'd14;

  typedef enum logic [2:0] {
    REG_SSRC         = 3'd0,
    REG_TS_STEP      = 3'd1,
    REG_PTYPE        = 3'd2,
    REG_SINGLE_LIMIT = 3'd3,
    REG_FRAG_LIMIT   = 3'd4,
    REG_SEQ_START    = 3'd5,
    REG_TS_START     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]       nal_byte;
    logic             nal_begin;
    logic [LEN_W-1:0] nal_length;
  } nal_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;
  } pkt_item_t;

  typedef struct packed {
    logic [31:0] ssrc;
    logic [31:0] ts_step;
    logic [6:0]  ptype;
    logic [15:0] single_limit;
    logic [15:0] frag_limit;
  } cfg_t;

  typedef struct packed {
    logic        seq_load;
    logic        ts_load;
    logic [31:0] value;
  } cfg_load_t;

  // One classified input byte: optional RTP header, optional FU bytes, then the payload byte.
  typedef struct packed {
    logic [7:0]  data;
    logic        pkt_end;
    logic        has_hdr;
    logic        marker;
    logic        has_fu;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [15:0] seq;
    logic [31:0] ts;
  } cmd_t;

endpackage

FILE: sv/hrfu_front.sv
// Front end of the packetizer: accepts NAL bytes, tracks packet state, issues commands.
// Depends on hrfu_pkg.
module hrfu_front import hrfu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      nal_valid,
  output logic      nal_stall,
  input  nal_item_t nal,
  input  cfg_t      cfg,
  input  cfg_load_t load,
  input  logic      q_full,
  output logic      push,
  output cmd_t      cmd
);

  logic [15:0]      seq_cnt, seq_cnt_next;
  logic [31:0]      ts_cnt, ts_cnt_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [15:0]      fill, fill_next;
  logic             fragmenting, fragmenting_next;
  logic             first_frag, first_frag_next;
  logic [7:0]       saved_hdr, saved_hdr_next;

  logic             accept;
  logic [LEN_W-1:0] len;
  logic [15:0]      flim;
  logic [16:0]      fill_inc;

  assign nal_stall = q_full;
  assign accept    = nal_valid && !q_full;
  assign len       = (nal.nal_length == '0) ? LEN_W'(1) : nal.nal_length;
  assign flim      = (cfg.frag_limit == 16'd0) ? 16'd1 : cfg.frag_limit;
  assign fill_inc  = {1'b0, fill} + 17'd1;

  always_comb begin
    seq_cnt_next     = seq_cnt;
    ts_cnt_next      = ts_cnt;
    remaining_next   = remaining;
    fill_next        = fill;
    fragmenting_next = fragmenting;
    first_frag_next  = first_frag;
    saved_hdr_next   = saved_hdr;
    push             = 1'b0;
    cmd              = '0;
    cmd.data         = nal.nal_byte;
    cmd.seq          = seq_cnt;
    cmd.ts           = ts_cnt;
    if (accept) begin
      if (nal.nal_begin) begin
        ts_cnt_next     = ts_cnt + cfg.ts_step;
        cmd.ts          = ts_cnt_next;
        remaining_next  = len - LEN_W'(1);
        fill_next       = '0;
        first_frag_next = 1'b1;
        if ({16'd0, len} <= {{LEN_W{1'b0}}, cfg.single_limit}) begin
          fragmenting_next = 1'b0;
          push             = 1'b1;
          cmd.has_hdr      = 1'b1;
          cmd.marker       = 1'b1;
          cmd.pkt_end      = (len == LEN_W'(1));
          seq_cnt_next     = seq_cnt + 16'd1;
        end else begin
          fragmenting_next = 1'b1;
          saved_hdr_next   = nal.nal_byte;
        end
      end else if (remaining != '0) begin
        remaining_next = remaining - LEN_W'(1);
        push           = 1'b1;
        if (!fragmenting) begin
          cmd.pkt_end = (remaining == LEN_W'(1));
        end else begin
          if (fill == 16'd0) begin
            cmd.has_hdr = 1'b1;
            cmd.has_fu  = 1'b1;
            cmd.fu_ind  = (saved_hdr & NRI_MASK) | FU_A_TYPE;
            // Start bit on the first fragment; end bit only on a later, final one.
            if (first_frag) begin
              cmd.fu_hdr = (saved_hdr & TYPE_MASK) | FU_S_BIT;
            end else if ({16'd0, remaining} <= {{LEN_W{1'b0}}, flim}) begin
              cmd.fu_hdr = (saved_hdr & TYPE_MASK) | FU_E_BIT;
            end else begin
              cmd.fu_hdr = saved_hdr & TYPE_MASK;
            end
            seq_cnt_next = seq_cnt + 16'd1;
          end
          if (fill_inc >= {1'b0, flim} || remaining == LEN_W'(1)) begin
            cmd.pkt_end     = 1'b1;
            fill_next       = '0;
            first_frag_next = 1'b0;
          end else begin
            fill_next = fill_inc[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cnt     <= '0;
      ts_cnt      <= '0;
      remaining   <= '0;
      fill        <= '0;
      fragmenting <= 1'b0;
      first_frag  <= 1'b1;
      saved_hdr   <= '0;
    end else begin
      seq_cnt     <= load.seq_load ? load.value[15:0] : seq_cnt_next;
      ts_cnt      <= load.ts_load ? load.value : ts_cnt_next;
      remaining   <= remaining_next;
      fill        <= fill_next;
      fragmenting <= fragmenting_next;
      first_frag  <= first_frag_next;
      saved_hdr   <= saved_hdr_next;
    end
  end

endmodule

FILE: sv/hrfu_queue.sv
// Short command queue between the packetizer front end and the byte emitter.
// Depends on hrfu_pkg.
module hrfu_queue import hrfu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full       = (count == QCNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/hrfu_back.sv
// Back end of the packetizer: expands queued commands into RTP beats.
// Depends on hrfu_pkg.
module hrfu_back import hrfu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head,
  output logic      pop,
  input  cfg_t      cfg,
  output logic      pkt_valid,
  input  logic      pkt_stall,
  output pkt_item_t pkt
);

  logic       mid;
  pos_t       pos;
  pos_t       cur, pos_next;
  logic       adv;
  logic [7:0] hdr_b [HDR_BYTES];
  logic [7:0] sel;

  assign cur = mid ? pos : (head.has_hdr ? POS_HDR_FIRST : POS_PAYLOAD);
  assign adv = head_valid && (!pkt_valid || !pkt_stall);
  assign pop = adv && (cur == POS_PAYLOAD);

  always_comb begin
    if (cur == POS_HDR_LAST) begin
      pos_next = head.has_fu ? POS_FU_IND : POS_PAYLOAD;
    end else begin
      pos_next = cur + 4'd1;
    end
  end

  always_comb begin
    hdr_b = '{RTP_BYTE0, {head.marker, cfg.ptype}, head.seq[15:8], head.seq[7:0],
              head.ts[31:24], head.ts[23:16], head.ts[15:8], head.ts[7:0],
              cfg.ssrc[31:24], cfg.ssrc[23:16], cfg.ssrc[15:8], cfg.ssrc[7:0],
              head.fu_ind, head.fu_hdr};
    sel = (cur == POS_PAYLOAD || cur > POS_PAYLOAD) ? head.data : hdr_b[cur];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pkt.out_byte   <= sel;
      pkt.packet_end <= (cur == POS_PAYLOAD) && head.pkt_end;
      pkt.run_last   <= (cur == POS_PAYLOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      mid       <= 1'b0;
      pos       <= POS_HDR_FIRST;
    end else begin
      if (!pkt_valid || !pkt_stall) begin
        pkt_valid <= head_valid;
      end
      if (adv) begin
        mid <= (cur != POS_PAYLOAD);
        pos <= pos_next;
      end
    end
  end

endmodule

FILE: sv/h264_rtp_fu_a_packetizer_core.sv
// H.264 RTP packetizer (single NAL and FU-A modes), top level.
// The first beat of an input byte passes through the command queue and then the output
// register before it is on pkt.
// Throughput: one output beat per cycle while pkt_stall is low; an input byte makes 1 beat
// for a plain payload byte, 13 for the start of a single packet and 15 for the start of a
// fragment. The byte emitter and its output register set that pace.
// Reset (rst, synchronous): counters cleared, queue emptied, registers at their defaults.
module h264_rtp_fu_a_packetizer_core import hrfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        nal_valid,
  output logic        nal_stall,
  input  nal_item_t   nal,
  output logic        pkt_valid,
  input  logic        pkt_stall,
  output pkt_item_t   pkt,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers. The port never pushes back, so every write beat
  // lands at once. Sequence and timestamp start values are not kept: writing
  // them loads the running counters in the front end directly.
  cfg_t      cfg;
  cfg_load_t load;
  logic      cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    load.seq_load = cfg_wr && (cfg_index == REG_SEQ_START);
    load.ts_load  = cfg_wr && (cfg_index == REG_TS_START);
    load.value    = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ssrc         <= '0;
      cfg.ts_step      <= 32'd3600;
      cfg.ptype        <= 7'd96;
      cfg.single_limit <= 16'd1400;
      cfg.frag_limit   <= 16'd1400;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_SSRC:         cfg.ssrc         <= cfg_data;
        REG_TS_STEP:      cfg.ts_step      <= cfg_data;
        REG_PTYPE:        cfg.ptype        <= cfg_data[6:0];
        REG_SINGLE_LIMIT: cfg.single_limit <= cfg_data[15:0];
        REG_FRAG_LIMIT:   cfg.frag_limit   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each NAL byte and updates sequence, timestamp and
  // fragment state in the cycle it is accepted. Bytes that make no beat (the
  // header byte of a fragmented NAL, stray bytes) are absorbed there.
  logic q_full, push, head_valid, pop;
  cmd_t push_cmd, head;

  hrfu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .nal_valid (nal_valid),
    .nal_stall (nal_stall),
    .nal       (nal),
    .cfg       (cfg),
    .load      (load),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // A two-entry queue lets the front keep taking bytes while the back end is
  // still streaming out a header.
  hrfu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // The back end walks header, FU bytes and payload one beat per cycle, while the output
  // is not stalled, into a registered output stage.
  hrfu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg        (cfg),
    .pkt_valid  (pkt_valid),
    .pkt_stall  (pkt_stall),
    .pkt        (pkt)
  );

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("command pushed into full queue");

  // A packet only ends on the payload beat, which is the last beat of its input byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && pkt.packet_end) |-> pkt.run_last)
    else $error("packet end on a beat that is not the last of its run");

  // Once a run has started, its beats follow without gaps.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && !pkt_stall && !pkt.run_last) |=> pkt_valid)
    else $error("gap inside a run of beats");

endmodule

FILE: tb/h264_rtp_fu_a_packetizer_core_tb.sv
// Self-checking testbench for the H.264 RTP FU-A packetizer core.
// Drives NAL byte beats and register writes, predicts every RTP output beat in-line.
// Depends on hrfu_pkg and h264_rtp_fu_a_packetizer_core.
`timescale 1ns / 100ps

module h264_rtp_fu_a_packetizer_core_tb;
  import hrfu_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 5;
  // The first output beat trails its input through the queue and output register; a NAL header
  // byte that opens a fragmented unit makes no beat at all, so give the block room to settle.
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        nal_valid = 1'b0;
  logic        nal_stall;
  nal_item_t   nal = '0;
  logic        pkt_valid;
  logic        pkt_stall = 1'b0;
  pkt_item_t   pkt;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  h264_rtp_fu_a_packetizer_core dut (
    .clk       (clk),
    .rst       (rst),
    .nal_valid (nal_valid),
    .nal_stall (nal_stall),
    .nal       (nal),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Register copies, held at their reset values until written.
  logic [31:0] cfg_ssrc       = '0;
  logic [31:0] cfg_ts_step    = 32'd3600;
  logic [6:0]  cfg_ptype      = 7'd96;
  logic [15:0] cfg_single_max = 16'd1400;
  logic [15:0] cfg_frag_max   = 16'd1400;

  // Packetizer state as the predictor sees it.
  logic [15:0] seq_count    = '0;
  logic [31:0] ts_count     = '0;
  logic [15:0] nal_left     = '0;
  logic [15:0] frag_fill    = '0;
  logic        in_fragments = 1'b0;
  logic        first_frag   = 1'b1;
  logic [7:0]  nal_header   = '0;

  nal_item_t nal_pending[$];     // NAL beats waiting for the driver
  pkt_item_t expected_bytes[$];  // RTP beats still owed by the block
  pkt_item_t burst[$];           // beats caused by the NAL beat being predicted

  int nal_beats_sent  = 0;
  int nal_beats_taken = 0;
  int pkt_beats_seen  = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  logic hold_req = 1'b0;
  logic hold_off = 1'b0;

  function automatic void emit(input logic [7:0] b, input logic pkt_last);
    pkt_item_t beat;
    beat.out_byte   = b;
    beat.packet_end = pkt_last;
    beat.run_last   = 1'b0;
    burst.push_back(beat);
  endfunction

  // Twelve-byte RTP header; every packet takes the current sequence number.
  function automatic void emit_rtp_header(input logic marker);
    emit(RTP_BYTE0, 1'b0);
    emit({marker, cfg_ptype}, 1'b0);
    emit(seq_count[15:8], 1'b0);
    emit(seq_count[7:0], 1'b0);
    emit(ts_count[31:24], 1'b0);
    emit(ts_count[23:16], 1'b0);
    emit(ts_count[15:8], 1'b0);
    emit(ts_count[7:0], 1'b0);
    emit(cfg_ssrc[31:24], 1'b0);
    emit(cfg_ssrc[23:16], 1'b0);
    emit(cfg_ssrc[15:8], 1'b0);
    emit(cfg_ssrc[7:0], 1'b0);
    seq_count = seq_count + 16'd1;
  endfunction

  // Works out every RTP beat that one accepted NAL beat causes and queues them.
  function automatic void packetize(input nal_item_t item);
    logic [15:0] len;
    logic [15:0] flim;
    logic [7:0]  fu_hdr;
    pkt_item_t   tail;
    burst.delete();
    if (item.nal_begin) begin
      // A new unit always restarts, even if the previous one was cut short.
      len = (item.nal_length == '0) ? 16'd1 : item.nal_length;
      ts_count   = ts_count + cfg_ts_step;
      nal_left   = len - 16'd1;
      frag_fill  = '0;
      first_frag = 1'b1;
      if (len <= cfg_single_max) begin
        in_fragments = 1'b0;
        emit_rtp_header(1'b1);
        emit(item.nal_byte, nal_left == '0);
      end else begin
        // The NAL header byte is only remembered; it goes out folded into the FU bytes.
        in_fragments = 1'b1;
        nal_header   = item.nal_byte;
      end
    end else if (nal_left != '0) begin
      if (!in_fragments) begin
        nal_left = nal_left - 16'd1;
        emit(item.nal_byte, nal_left == '0);
      end else begin
        flim = (cfg_frag_max == '0) ? 16'd1 : cfg_frag_max;
        if (frag_fill == '0) begin
          fu_hdr = nal_header & TYPE_MASK;
          if (first_frag) begin
            fu_hdr = fu_hdr | FU_S_BIT;
          end else if (nal_left <= flim) begin
            fu_hdr = fu_hdr | FU_E_BIT;
          end
          emit_rtp_header(1'b0);
          emit((nal_header & NRI_MASK) | FU_A_TYPE, 1'b0);
          emit(fu_hdr, 1'b0);
        end
        nal_left  = nal_left - 16'd1;
        frag_fill = frag_fill + 16'd1;
        if (frag_fill >= flim || nal_left == '0) begin
          emit(item.nal_byte, 1'b1);
          frag_fill  = '0;
          first_frag = 1'b0;
        end else begin
          emit(item.nal_byte, 1'b0);
        end
      end
    end
    if (burst.size() != 0) begin
      tail = burst[burst.size() - 1];
      tail.run_last = 1'b1;
      burst[burst.size() - 1] = tail;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
    end
  endfunction

  // Driver: a beat is presented at a falling edge and held until the monitor has
  // counted it as taken, so a stalled payload never changes.
  always @(negedge clk) begin
    if (!rst && nal_beats_taken == nal_beats_sent) begin
      if (nal_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nal <= nal_pending.pop_front();
        nal_valid <= 1'b1;
        nal_beats_sent++;
      end else begin
        nal_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls at random, or solidly while the long hold-off runs.
  always @(negedge clk) begin
    pkt_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
  end

  // Long hold-off, counted here: the output stays blocked while the driver keeps
  // offering beats, so the block's queue fills and it must stall its input.
  initial begin
    wait (hold_req);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: predicts on every accepted NAL beat and checks every accepted RTP beat
  // against the oldest outstanding expectation.
  always @(posedge clk) begin
    pkt_item_t want;
    if (!rst) begin
      if (nal_valid && !nal_stall) begin
        nal_beats_taken++;
        packetize(nal);
      end
      if (pkt_valid && !pkt_stall) begin
        pkt_beats_seen++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("beat %0d: unexpected byte %02h end %b last %b", pkt_beats_seen,
                     pkt.out_byte, pkt.packet_end, pkt.run_last);
          end
        end else begin
          want = expected_bytes.pop_front();
          if (pkt.out_byte !== want.out_byte || pkt.packet_end !== want.packet_end ||
              pkt.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("beat %0d: expected byte %02h end %b last %b, got %02h end %b last %b",
                       pkt_beats_seen, want.out_byte, want.packet_end, want.run_last,
                       pkt.out_byte, pkt.packet_end, pkt.run_last);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void offer(input logic [7:0] b, input logic first_beat,
                                input logic [15:0] len);
    nal_item_t item;
    item.nal_byte   = b;
    item.nal_begin  = first_beat;
    item.nal_length = len;
    nal_pending.push_back(item);
  endfunction

  // A NAL start with the given length field, followed by continuation beats up to
  // beat_count in all. Continuation beats carry random length fields, which the block
  // must ignore.
  function automatic void offer_nal(input logic [15:0] len, input int beat_count);
    offer(8'($urandom_range(255)), 1'b1, len);
    for (int i = 1; i < beat_count; i++) begin
      offer(8'($urandom_range(255)), 1'b0, 16'($urandom_range(16'hffff)));
    end
  endfunction

  // Mostly complete NALs of small random length; the rest are units cut short by the
  // next start (with any length field at all) and stray bytes between units.
  function automatic void random_traffic(input int count, input int max_len);
    int made;
    int pick;
    int len;
    int cut;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(max_len);
        offer_nal(len[15:0], (len == 0) ? 1 : len);
        made += (len == 0) ? 1 : len;
      end else if (pick < 90) begin
        cut = $urandom_range(3, 1);
        offer_nal(16'($urandom_range(16'hffff)), cut);
        made += cut;
      end else begin
        offer(8'($urandom_range(255)), 1'b0, 16'($urandom_range(16'hffff)));
        made += 1;
      end
    end
  endfunction

  // Register write; the predictor takes the new value at the handshake.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SSRC:         cfg_ssrc = val;
      REG_TS_STEP:      cfg_ts_step = val;
      REG_PTYPE:        cfg_ptype = val[6:0];
      REG_SINGLE_LIMIT: cfg_single_max = val[15:0];
      REG_FRAG_LIMIT:   cfg_frag_max = val[15:0];
      REG_SEQ_START:    seq_count = val[15:0];
      REG_TS_START:     ts_count = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued beat is taken and every predicted beat has arrived,
  // then lets the block settle.
  task automatic drain();
    while (nal_pending.size() != 0 || nal_beats_taken != nal_beats_sent ||
           expected_bytes.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic begin_phase(input int tx_pct, input int rx_pct);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed phase: extreme register values, a timestamp that steps backwards
    // and a sequence number that wraps within the first few packets.
    write_reg(REG_SSRC, 32'hffff_ffff);
    write_reg(REG_TS_STEP, 32'hffff_ffff);
    write_reg(REG_PTYPE, 32'd127);
    write_reg(REG_SINGLE_LIMIT, 32'd3);
    write_reg(REG_FRAG_LIMIT, 32'd2);
    write_reg(REG_SEQ_START, 32'h0000_fffe);
    write_reg(REG_TS_START, 32'd5);
    begin_phase(6, 58);
    offer(8'h00, 1'b0, 16'hffff);    // stray byte with no unit open: ignored
    offer(8'h00, 1'b1, 16'd1);       // one-byte unit sent whole
    offer(8'hff, 1'b1, 16'd3);       // unit exactly at the single-packet limit
    offer(8'h5a, 1'b0, 16'h0000);
    offer(8'ha5, 1'b0, 16'hffff);
    offer(8'h67, 1'b1, 16'd0);       // zero length counts as one byte
    offer_nal(16'd5, 5);             // two fragments: start, then end
    offer_nal(16'd6, 6);             // three fragments, the last one short
    offer_nal(16'd4, 2);             // cut short by the next start
    offer_nal(16'd2, 2);
    offer(8'h3c, 1'b0, 16'h8001);    // trailing byte after a finished unit
    drain();

    // Every unit fragmented, with a zero fragment limit meaning one byte each.
    write_reg(REG_SSRC, 32'h0);
    write_reg(REG_TS_STEP, 32'h0);
    write_reg(REG_PTYPE, 32'h0);
    write_reg(REG_SINGLE_LIMIT, 32'h0);
    write_reg(REG_FRAG_LIMIT, 32'h0);
    begin_phase(6, 58);
    offer_nal(16'd1, 1);             // header-only fragmented unit: no packet at all
    random_traffic(16, 6);
    drain();

    // Nothing fragmented; a maximum-length unit is started and abandoned.
    write_reg(REG_SINGLE_LIMIT, 32'h0000_ffff);
    write_reg(REG_FRAG_LIMIT, 32'h0000_ffff);
    write_reg(REG_TS_STEP, $urandom);
    write_reg(REG_PTYPE, $urandom_range(127));
    write_reg(REG_SEQ_START, 32'h0);
    write_reg(REG_TS_START, 32'hffff_ffff);
    begin_phase(58, 6);
    offer_nal(16'hffff, 3);
    random_traffic(16, 8);
    drain();

    write_reg(REG_SSRC, $urandom);
    write_reg(REG_PTYPE, $urandom_range(127));
    write_reg(REG_SINGLE_LIMIT, 32'd4);
    write_reg(REG_FRAG_LIMIT, 32'd3);
    write_reg(REG_SEQ_START, $urandom_range(16'hffff));
    begin_phase(58, 6);
    random_traffic(18, 10);
    drain();

    // Back-to-back traffic with the output held off for a long stretch.
    write_reg(REG_SSRC, $urandom);
    write_reg(REG_TS_STEP, $urandom);
    write_reg(REG_SINGLE_LIMIT, $urandom_range(5, 1));
    write_reg(REG_FRAG_LIMIT, $urandom_range(4, 1));
    write_reg(REG_TS_START, $urandom);
    begin_phase(0, 0);
    hold_req = 1'b1;
    random_traffic(18, 9);
    drain();

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
